FILE: design/spi_mp_pkg.sv
// Shared types and constants for the SPI master peripheral.
package spi_mp_pkg;

  // Frame geometry
  localparam int MAX_FRAME_BITS = 16;
  localparam int NARROW_BITS    = 8;
  localparam int DATA_W         = MAX_FRAME_BITS;
  localparam int EDGE_W         = 6;
  localparam int PRESCALE_W     = 7;
  localparam int BAUD_W         = 3;

  localparam logic [EDGE_W-1:0] EDGES_WIDE   = EDGE_W'(2 * MAX_FRAME_BITS);
  localparam logic [EDGE_W-1:0] EDGES_NARROW = EDGE_W'(2 * NARROW_BITS);
  localparam logic [DATA_W-1:0] MASK_WIDE    = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] MASK_NARROW  = DATA_W'({NARROW_BITS{1'b1}});

  // Stream payload widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 3;

  // Bus access kinds carried in s_tuser
  typedef enum logic [S_TUSER_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_STATUS = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAUD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LSB      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd5;

endpackage

FILE: design/spi_master_peripheral.sv
// SPI master peripheral: bus access stream in, one status/data item out per access.
//
// Usage:
//   s_* carries bus accesses: s_tuser is the access kind (tick, data write, data
//   read, status read); s_tdata carries the write data and the sampled MISO level.
//   Every accepted item yields exactly one result item on m_*: read data (zero
//   unless a data read), the transmit-empty, receive-not-empty and busy flags,
//   and the SCK and MOSI line levels after the access.
//   cfg_* writes one configuration register per handshake (index, 3-bit data);
//   it is always ready and should be written only while no frame is shifting.
//   Results are registered: a result is visible on m_* the cycle after its
//   item is accepted. One item per cycle is taken while m_tready keeps up:
//   the state update and the result are computed in the accepting cycle, and
//   the output register reloads in the same cycle that its item is taken.
//   A tick advances the baud prescaler; a frame takes 2 * frame_bits * 2^baud
//   ticks after its starting tick.
//   When the receiver stalls, the output register holds its item and s_tready
//   drops until it is taken; nothing is lost.
//   Synchronous reset clears all flags and buffers, sets transmit-empty, resets
//   the configuration to zero and empties the output register.
module spi_master_peripheral (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] write_data, [16] miso, [23:17] zero
  input  logic [spi_mp_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [spi_mp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] read_data, [16] tx_empty, [17] rx_not_empty, [18] busy_res,
  // [19] sck, [20] mosi, [23:21] zero
  output logic [spi_mp_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spi_mp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spi_mp_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import spi_mp_pkg::*;

  // Configuration registers
  logic [BAUD_W-1:0] baud_select;
  logic              clock_polarity;
  logic              clock_phase;
  logic              frame_sixteen;
  logic              lsb_first;
  logic              enable;

  // Shifter state
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [DATA_W-1:0]     tx_holding, tx_holding_next;
  logic                  tx_empty_flag, tx_empty_flag_next;
  logic [DATA_W-1:0]     shift_out, shift_out_next;
  logic [DATA_W-1:0]     shift_in, shift_in_next;
  logic [DATA_W-1:0]     rx_holding, rx_holding_next;
  logic                  rx_full_flag, rx_full_flag_next;
  logic [EDGE_W-1:0]     edges_left, edges_left_next;
  logic                  busy_flag, busy_flag_next;
  logic                  clock_level, clock_level_next;

  // Handshake and decoded payload
  logic              s_accept;
  func_t             func;
  logic [DATA_W-1:0] write_data;
  logic              miso;
  logic [DATA_W-1:0] read_data_next;
  logic              mosi_next;
  logic              sck_next;

  // Edge helpers
  logic [DATA_W-1:0] frame_mask;
  logic [EDGE_W-1:0] frame_edges;
  logic [EDGE_W-1:0] edge_rem;
  logic              edge_due;
  logic              do_sample;
  logic              do_shift;
  logic [DATA_W-1:0] sampled_in;
  logic [DATA_W-1:0] shifted_out;
  logic [DATA_W-1:0] miso_top;

  assign s_tready   = !m_tvalid || m_tready;
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign func       = func_t'(s_tuser);
  assign write_data = s_tdata[DATA_W-1:0];
  assign miso       = s_tdata[DATA_W];

  assign frame_mask  = frame_sixteen ? MASK_WIDE : MASK_NARROW;
  assign frame_edges = frame_sixteen ? EDGES_WIDE : EDGES_NARROW;

  // Prescaler reaches the half-period on this tick
  assign edge_due = ({1'b0, prescale_count} + (PRESCALE_W+1)'(1))
                    >= ((PRESCALE_W+1)'(1) << baud_select);

  // Edge classification from the remaining edge count
  always_comb begin
    edge_rem = edges_left - EDGE_W'(1);
    if (clock_phase) begin
      do_sample = !edge_rem[0];
      do_shift  = edge_rem[0] && (edge_rem != (frame_edges - EDGE_W'(1)));
    end else begin
      do_sample = edge_rem[0];
      do_shift  = !edge_rem[0];
    end
  end

  // Shift data for one serial clock edge
  always_comb begin
    miso_top = frame_sixteen ? {miso, {(DATA_W-1){1'b0}}}
                             : DATA_W'({miso, {(NARROW_BITS-1){1'b0}}});
    if (lsb_first) begin
      sampled_in  = ((shift_in & frame_mask) >> 1) | miso_top;
      shifted_out = (shift_out & frame_mask) >> 1;
    end else begin
      sampled_in  = ((shift_in << 1) | DATA_W'(miso)) & frame_mask;
      shifted_out = (shift_out << 1) & frame_mask;
    end
  end

  // Next state and result for the accepted item
  always_comb begin
    prescale_count_next = prescale_count;
    tx_holding_next     = tx_holding;
    tx_empty_flag_next  = tx_empty_flag;
    shift_out_next      = shift_out;
    shift_in_next       = shift_in;
    rx_holding_next     = rx_holding;
    rx_full_flag_next   = rx_full_flag;
    edges_left_next     = edges_left;
    busy_flag_next      = busy_flag;
    clock_level_next    = clock_level;
    read_data_next      = '0;

    unique case (func)
      FUNC_TICK: begin
        if (!busy_flag) begin
          clock_level_next = clock_polarity;
          if (enable && !tx_empty_flag) begin
            shift_out_next      = tx_holding & frame_mask;
            shift_in_next       = '0;
            tx_empty_flag_next  = 1'b1;
            busy_flag_next      = 1'b1;
            edges_left_next     = frame_edges;
            prescale_count_next = '0;
          end
        end else if (edge_due) begin
          prescale_count_next = '0;
          edges_left_next     = edge_rem;
          clock_level_next    = !clock_level;
          if (do_sample) shift_in_next = sampled_in;
          if (do_shift) shift_out_next = shifted_out;
          if (edge_rem == '0) begin
            rx_holding_next   = (do_sample ? sampled_in : shift_in) & frame_mask;
            rx_full_flag_next = 1'b1;
            busy_flag_next    = 1'b0;
            clock_level_next  = clock_polarity;
          end
        end else begin
          prescale_count_next = prescale_count + PRESCALE_W'(1);
        end
      end
      FUNC_WRITE: begin
        tx_holding_next    = write_data;
        tx_empty_flag_next = 1'b0;
      end
      FUNC_READ: begin
        read_data_next    = rx_holding;
        rx_full_flag_next = 1'b0;
      end
      FUNC_STATUS: begin
        read_data_next = '0;
      end
      default: begin
        read_data_next = '0;
      end
    endcase

    // Line levels after the access
    if (!busy_flag_next) begin
      sck_next  = clock_polarity;
      mosi_next = 1'b0;
    end else begin
      sck_next  = clock_level_next;
      mosi_next = lsb_first ? shift_out_next[0]
                            : (frame_sixteen ? shift_out_next[DATA_W-1]
                                             : shift_out_next[NARROW_BITS-1]);
    end
  end

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      baud_select    <= '0;
      clock_polarity <= 1'b0;
      clock_phase    <= 1'b0;
      frame_sixteen  <= 1'b0;
      lsb_first      <= 1'b0;
      enable         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAUD:     baud_select    <= cfg_data;
        REG_POLARITY: clock_polarity <= cfg_data[0];
        REG_PHASE:    clock_phase    <= cfg_data[0];
        REG_SIXTEEN:  frame_sixteen  <= cfg_data[0];
        REG_LSB:      lsb_first      <= cfg_data[0];
        REG_ENABLE:   enable         <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Control state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      tx_empty_flag  <= 1'b1;
      rx_full_flag   <= 1'b0;
      edges_left     <= '0;
      busy_flag      <= 1'b0;
      clock_level    <= 1'b0;
    end else if (s_accept) begin
      prescale_count <= prescale_count_next;
      tx_empty_flag  <= tx_empty_flag_next;
      rx_full_flag   <= rx_full_flag_next;
      edges_left     <= edges_left_next;
      busy_flag      <= busy_flag_next;
      clock_level    <= clock_level_next;
    end
  end

  // Data buffers and shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_holding <= '0;
      shift_out  <= '0;
      shift_in   <= '0;
      rx_holding <= '0;
    end else if (s_accept) begin
      tx_holding <= tx_holding_next;
      shift_out  <= shift_out_next;
      shift_in   <= shift_in_next;
      rx_holding <= rx_holding_next;
    end
  end

  // Output register: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {3'b000, mosi_next, sck_next, busy_flag_next, rx_full_flag_next,
                  tx_empty_flag_next, read_data_next};
    end
  end

  // A shifting frame always has edges left to run
  assert property (@(posedge clk) disable iff (rst) busy_flag |-> edges_left != '0)
    else $error("busy with no edges left");

  // A data write leaves the holding buffer full
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && func == FUNC_WRITE) |=> !tx_empty_flag)
    else $error("data write did not fill the holding buffer");

  // A frame starts only by draining the holding buffer
  assert property (@(posedge clk) disable iff (rst) $rose(busy_flag) |-> tx_empty_flag)
    else $error("frame started without draining the holding buffer");

  // A finished frame lands in the receive buffer
  assert property (@(posedge clk) disable iff (rst) $fell(busy_flag) |-> rx_full_flag)
    else $error("frame ended without filling the receive buffer");

endmodule

FILE: tb/spi_mp_checker.sv
// Checker for the SPI master peripheral: predicts each result item and compares it.
`timescale 1ns / 1ps

module spi_mp_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [spi_mp_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [spi_mp_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [spi_mp_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [spi_mp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spi_mp_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                              run_done,
  output int                                pending,
  output int                                fail_count
);
  import spi_mp_pkg::*;

  // Result item layout, highest bits first
  typedef struct packed {
    logic [2:0]        pad;
    logic              mosi;
    logic              sck;
    logic              busy;
    logic              rx_ne;
    logic              tx_empty;
    logic [DATA_W-1:0] rd;
  } spi_word_t;

  // Configuration copy
  logic [BAUD_W-1:0]     baud;
  logic                  cpol, cpha, wide, lsbf, en;

  // Shifter and buffer state
  logic [PRESCALE_W-1:0] pre_cnt;
  logic [DATA_W-1:0]     tx_hold, sh_out, sh_in, rx_hold;
  logic                  tx_empty, rx_full, busy, sck_lvl;
  logic [EDGE_W-1:0]     edges_left;

  spi_word_t status_due_q[$];
  spi_word_t want, seen;
  int        mismatches = 0;
  logic      leftover_seen;

  assign fail_count = mismatches;

  function automatic int frame_len();
    return wide ? MAX_FRAME_BITS : NARROW_BITS;
  endfunction

  function automatic logic [DATA_W-1:0] frame_mask();
    return wide ? MASK_WIDE : MASK_NARROW;
  endfunction

  function automatic void clear_model();
    baud = '0; cpol = 1'b0; cpha = 1'b0; wide = 1'b0; lsbf = 1'b0; en = 1'b0;
    pre_cnt = '0; tx_hold = '0; sh_out = '0; sh_in = '0; rx_hold = '0;
    tx_empty = 1'b1; rx_full = 1'b0; busy = 1'b0; sck_lvl = 1'b0;
    edges_left = '0;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_BAUD:     baud = val;
      REG_POLARITY: cpol = val[0];
      REG_PHASE:    cpha = val[0];
      REG_SIXTEEN:  wide = val[0];
      REG_LSB:      lsbf = val[0];
      REG_ENABLE:   en   = val[0];
      default: ;
    endcase
    if (!busy) sck_lvl = cpol;
  endfunction

  // One SCK transition: sample MISO and/or advance the outgoing word
  function automatic void sck_edge(input logic mi);
    int                bits;
    logic [DATA_W-1:0] mask;
    logic [EDGE_W-1:0] total;
    logic              odd, take, move;
    bits  = frame_len();
    mask  = frame_mask();
    total = wide ? EDGES_WIDE : EDGES_NARROW;
    edges_left = edges_left - 1'b1;
    sck_lvl = ~sck_lvl;
    odd = edges_left[0];
    if (cpha) begin
      take = !odd;
      move = odd && (edges_left != total - 1'b1);
    end else begin
      take = odd;
      move = !odd;
    end
    if (take) begin
      if (lsbf) sh_in = ((sh_in & mask) >> 1) | (DATA_W'(mi) << (bits - 1));
      else      sh_in = ((sh_in << 1) | DATA_W'(mi)) & mask;
    end
    if (move) begin
      if (lsbf) sh_out = (sh_out & mask) >> 1;
      else      sh_out = (sh_out << 1) & mask;
    end
    // last edge: hand the frame to the receive buffer and go idle
    if (edges_left == '0) begin
      rx_hold = sh_in & mask;
      rx_full = 1'b1;
      busy    = 1'b0;
      sck_lvl = cpol;
    end
  endfunction

  // One peripheral clock tick: start a frame or run the baud prescaler
  function automatic void sck_tick(input logic mi);
    if (!busy) begin
      sck_lvl = cpol;
      if (en && !tx_empty) begin
        sh_out     = tx_hold & frame_mask();
        sh_in      = '0;
        tx_empty   = 1'b1;
        busy       = 1'b1;
        edges_left = wide ? EDGES_WIDE : EDGES_NARROW;
        pre_cnt    = '0;
      end
    end else if (int'(pre_cnt) + 1 >= (1 << baud)) begin
      pre_cnt = '0;
      sck_edge(mi);
    end else begin
      pre_cnt = pre_cnt + 1'b1;
    end
  endfunction

  function automatic spi_word_t spi_access(input func_t f, input logic [DATA_W-1:0] wd,
                                           input logic mi);
    spi_word_t r;
    r = '0;
    case (f)
      FUNC_TICK:  sck_tick(mi);
      FUNC_WRITE: begin
        tx_hold  = wd;
        tx_empty = 1'b0;
      end
      FUNC_READ: begin
        r.rd    = rx_hold;
        rx_full = 1'b0;
      end
      default: ;
    endcase
    if (!busy) sck_lvl = cpol;
    else       r.mosi = lsbf ? sh_out[0] : sh_out[frame_len() - 1];
    r.tx_empty = tx_empty;
    r.rx_ne    = rx_full;
    r.busy     = busy;
    r.sck      = sck_lvl;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic match_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  // Compare each result, predict on each accepted access, then track config writes
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      status_due_q.delete();
      leftover_seen = 1'b0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (status_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result item 0x%06h", m_tdata));
        end else begin
          want = status_due_q.pop_front();
          match_field("read_data", seen.rd, want.rd);
          match_field("tx_empty", seen.tx_empty, want.tx_empty);
          match_field("rx_not_empty", seen.rx_ne, want.rx_ne);
          match_field("busy_res", seen.busy, want.busy);
          match_field("sck", seen.sck, want.sck);
          match_field("mosi", seen.mosi, want.mosi);
        end
      end
      if (s_tvalid && s_tready)
        status_due_q.push_back(spi_access(func_t'(s_tuser), s_tdata[DATA_W-1:0],
                                          s_tdata[DATA_W]));
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (run_done && !leftover_seen) begin
        leftover_seen = 1'b1;
        if (status_due_q.size() != 0)
          flag_mismatch($sformatf("%0d result items never arrived", status_due_q.size()));
      end
      pending <= status_due_q.size();
    end
  end

endmodule

FILE: tb/tb_spi_master_peripheral.sv
// Testbench top for the SPI master peripheral: bus access stimulus and verdict.
`timescale 1ns / 1ps

module tb_spi_master_peripheral;
  import spi_mp_pkg::*;

  localparam int BUSY_BIT     = DATA_W + 2;
  localparam int RANDOM_ITEMS = 420;

  typedef struct {
    logic [BAUD_W-1:0] baud;
    logic              cpol, cpha, wide, lsbf, en;
  } spi_setup_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 run_done = 1'b0;
  int                   pending;
  int                   fail_count;

  logic       last_busy;
  int         items_sent = 0;
  int         burst_left = 0;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         stall_tick = 0;
  spi_setup_t cur;

  spi_master_peripheral dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spi_mp_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .run_done(run_done), .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("spi_master_peripheral test failed");
    $finish;
  end

  // Receiver: switch between stall patterns at random intervals
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_tick % 5 != 0);
    endcase
  end

  // Remember whether the latest result item showed a frame in flight
  always @(posedge clk) begin
    if (rst)                      last_busy <= 1'b0;
    else if (m_tvalid && m_tready) last_busy <= m_tdata[BUSY_BIT];
  end

  // Send one bus access; bursts of back-to-back items with random gaps between
  task automatic put_item(input func_t f, input logic [DATA_W-1:0] wd, input logic mi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {7'd0, mi, wd};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Stop sending, then tick until the block reports no frame in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    wait_drained();
    while (last_busy) begin
      repeat (8) put_item(FUNC_TICK, DATA_W'($urandom), 1'($urandom));
      s_tvalid <= 1'b0;
      wait_drained();
    end
    repeat (3) @(posedge clk);
  endtask

  // Write all six registers back to back; single-bit ones get junk upper bits
  task automatic load_setup(input spi_setup_t c);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_DAT_W-1:0] val [6];
    idx = '{REG_BAUD, REG_POLARITY, REG_PHASE, REG_SIXTEEN, REG_LSB, REG_ENABLE};
    val = '{c.baud, {2'($urandom), c.cpol}, {2'($urandom), c.cpha},
            {2'($urandom), c.wide}, {2'($urandom), c.lsbf}, {2'($urandom), c.en}};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur = c;
  endtask

  function automatic spi_setup_t pick_setup(input int p);
    spi_setup_t c;
    case (p)
      0:       c = '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      1:       c = '{3'd1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      2:       c = '{3'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
      3:       c = '{3'd2, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      4:       c = '{3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
      5:       c = '{3'd1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
      default: c = '{BAUD_W'($urandom_range(0, 2)), 1'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom), ($urandom_range(0, 5) != 0)};
    endcase
    return c;
  endfunction

  // Write a word, tick through a frame (or part of one), read the result back;
  // a tenth of the time send a few random accesses instead
  task automatic run_exchange(input logic whole);
    int          kind, n, span;
    logic [15:0] word;
    span = (2 * (cur.wide ? MAX_FRAME_BITS : NARROW_BITS)) << cur.baud;
    kind = whole ? 9 : $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4))
        put_item(func_t'($urandom_range(0, 3)), DATA_W'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = DATA_W'($urandom);
      endcase
      put_item(FUNC_WRITE, word, 1'($urandom));
      n = (kind == 1) ? $urandom_range(0, span) : span + 1 + $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 39))
          0, 1, 2: put_item(FUNC_STATUS, DATA_W'($urandom), 1'($urandom));
          3:       put_item(FUNC_READ, DATA_W'($urandom), 1'($urandom));
          4:       put_item(FUNC_WRITE, DATA_W'($urandom), 1'($urandom));
          default: ;
        endcase
        put_item(FUNC_TICK, DATA_W'($urandom), 1'($urandom));
      end
      put_item(FUNC_READ, DATA_W'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int p, goal, budget;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cur = '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // Disabled after reset: read with nothing received, overwrite a full buffer
    put_item(FUNC_READ, 16'hFFFF, 1'b1);
    put_item(FUNC_STATUS, 16'h0000, 1'b0);
    put_item(FUNC_WRITE, 16'hFFFF, 1'b1);
    put_item(FUNC_TICK, 16'h0000, 1'b1);
    put_item(FUNC_TICK, 16'hFFFF, 1'b0);
    put_item(FUNC_WRITE, 16'h0000, 1'b0);
    put_item(FUNC_WRITE, 16'h96A5, 1'b1);
    settle();

    // Enable: the held word starts, a second write lands while shifting
    load_setup(pick_setup(0));
    repeat (8) put_item(FUNC_TICK, 16'h0000, 1'($urandom));
    put_item(FUNC_WRITE, 16'hFFFF, 1'b0);
    repeat (9) put_item(FUNC_TICK, 16'hFFFF, 1'($urandom));
    put_item(FUNC_READ, 16'h0000, 1'b1);
    settle();

    // Random phases over several register settings
    p = 0;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      load_setup(pick_setup(p));
      budget = items_sent + $urandom_range(50, 90);
      while (items_sent < budget) run_exchange(1'b0);
      settle();
      p++;
    end

    // Slower baud rate, one whole frame
    load_setup('{3'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1});
    run_exchange(1'b1);
    settle();

    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("spi_master_peripheral test passed");
    end else begin
      $display("spi_master_peripheral test failed");
    end
    $finish;
  end

endmodule
